### rtl/frame_receiver_checksum_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame receiver checksum block
// Same-cycle and next-cycle implication checks, clocked on clk, held off
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FRAME_RECEIVER_CHECKSUM_MACROS_SVH
`define FRAME_RECEIVER_CHECKSUM_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frc check failed in current cycle");

// consequent must hold in the cycle after the antecedent
`define FRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frc check failed in next cycle");

`endif

### rtl/frc_pkg.sv
// ---------------------------------------------------------------------------
// frc_pkg
// Shared types, status codes and widths of the frame receiver checksum block.
// ---------------------------------------------------------------------------
package frc_pkg;

    localparam int FRC_LENGTH_BITS = 16;
    localparam int FRC_BYTE_W      = 8;
    localparam int FRC_INDEX_W     = 16;
    localparam int FRC_STATUS_W    = 3;
    localparam int FRC_OUT_TDATA_W = 40;

    localparam logic [FRC_BYTE_W-1:0] FRC_RESET_ID = 8'd97;

    typedef enum logic [FRC_STATUS_W-1:0] {
        ST_HEADER      = 3'd0,
        ST_DATA        = 3'd1,
        ST_GOOD        = 3'd2,
        ST_BAD         = 3'd3,
        ST_ID_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic [FRC_BYTE_W-1:0]    data_byte;
        logic [FRC_INDEX_W-1:0]   data_index;
        logic [FRC_INDEX_W-1:0]   frame_length;
    } result_t;

endpackage

### rtl/frc_parser.sv
// ---------------------------------------------------------------------------
// frc_parser
// Frame phase tracking, length capture and checksum accumulation; forms the
// result for the byte being transferred in the same cycle.
// ---------------------------------------------------------------------------
module frc_parser #(
    parameter int LENGTH_BITS = frc_pkg::FRC_LENGTH_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_load,
    input  logic [frc_pkg::FRC_BYTE_W-1:0]      cfg_data,
    input  logic                                in_load,
    input  logic [frc_pkg::FRC_BYTE_W-1:0]      in_byte,
    output frc_pkg::result_t                    result
);
    import frc_pkg::*;

    typedef enum logic [2:0] {
        PH_ID     = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_SUM    = 3'd4
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [FRC_INDEX_W-1:0]   idx_reg, idx_next;
    logic [FRC_BYTE_W-1:0]    sum_reg, sum_next;
    logic [FRC_BYTE_W-1:0]    id_reg;
    logic [FRC_INDEX_W-1:0]   hi_word;
    logic [FRC_INDEX_W-1:0]   idx_inc;

    assign hi_word = {in_byte, {FRC_BYTE_W{1'b0}}};
    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        phase_next        = phase_reg;
        len_next          = len_reg;
        idx_next          = idx_reg;
        sum_next          = sum_reg;
        result.status     = ST_HEADER;
        result.data_byte  = '0;
        result.data_index = '0;
        case (phase_reg)
            PH_LEN_HI:
            begin
                len_next   = hi_word[LENGTH_BITS-1:0];
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = len_reg | LENGTH_BITS'(in_byte);
                phase_next = (len_next == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                result.status     = ST_DATA;
                result.data_byte  = in_byte;
                result.data_index = idx_reg;
                sum_next          = sum_reg + in_byte;
                idx_next          = idx_inc;
                if (idx_inc >= FRC_INDEX_W'(len_reg))
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                result.status = (in_byte == sum_reg) ? ST_GOOD : ST_BAD;
                phase_next    = PH_ID;
            end
            default:
            begin
                if (in_byte == id_reg)
                begin
                    len_next   = '0;
                    idx_next   = '0;
                    sum_next   = '0;
                    phase_next = PH_LEN_HI;
                end
                else
                begin
                    result.status = ST_ID_MISMATCH;
                    phase_next    = PH_ID;
                end
            end
        endcase
        result.frame_length = FRC_INDEX_W'(len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            id_reg    <= FRC_RESET_ID;
        end
        else
        begin
            if (cfg_load)
            begin
                id_reg <= cfg_data;
            end
            if (in_load)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                idx_reg   <= idx_next;
                sum_reg   <= sum_next;
            end
        end
    end

endmodule

### rtl/frc_out_stage.sv
// ---------------------------------------------------------------------------
// frc_out_stage
// Result register of the output stream; loads while empty or draining.
// ---------------------------------------------------------------------------
module frc_out_stage (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  frc_pkg::result_t                       result,
    output logic                                   ready,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [frc_pkg::FRC_OUT_TDATA_W-1:0]    m_tdata,
    output logic [frc_pkg::FRC_STATUS_W-1:0]       m_tuser
);
    import frc_pkg::*;

    logic                        valid_reg;
    logic [FRC_OUT_TDATA_W-1:0]  data_reg;
    logic [FRC_STATUS_W-1:0]     user_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {result.frame_length, result.data_index, result.data_byte};
            user_reg <= result.status;
        end
    end

endmodule

### rtl/frame_receiver_checksum.sv
// ---------------------------------------------------------------------------
// frame_receiver_checksum
// Length-prefixed frame deframer with 8-bit additive payload checksum.
// ---------------------------------------------------------------------------
// Input stream s_*: one received byte per transfer. Frames are laid out as
// an ID byte, length high, length low, that many payload bytes, then a
// checksum byte (8-bit wrapping sum of the payload bytes).
// Output stream m_*: exactly one result per input byte. m_tuser carries the
// status (0 header, 1 payload, 2 frame good, 3 checksum bad, 4 ID mismatch);
// m_tdata carries payload byte, payload index and the frame length.
// Config channel cfg_*: writes the expected ID byte; always ready, to be
// written only while the block is idle.
// An input transfer's result is registered and shows on m_* in the next cycle. One
// byte per cycle is sustained unless m_* stalls: the phase logic works on the byte as
// it transfers and the result register is reloaded in the cycle the receiver takes it.
// When m_tready is low with a result held, s_tready drops until it drains.
// Reset clears the output valid, returns to waiting for an ID and sets
// the expected ID to 97.
// ---------------------------------------------------------------------------
module frame_receiver_checksum #(
    parameter int LENGTH_BITS = frc_pkg::FRC_LENGTH_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [frc_pkg::FRC_BYTE_W-1:0]         cfg_data,     // expected_id
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [frc_pkg::FRC_BYTE_W-1:0]         s_tdata,      // rx_byte
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // data_byte[7:0], data_index[23:8], frame_length[39:24]
    output logic [frc_pkg::FRC_OUT_TDATA_W-1:0]    m_tdata,
    output logic [frc_pkg::FRC_STATUS_W-1:0]       m_tuser       // status
);
    import frc_pkg::*;

    logic     stage_ready;
    logic     in_load;
    result_t  result;

    assign cfg_ready = 1'b1;
    assign s_tready  = stage_ready;
    assign in_load   = s_tvalid && stage_ready;

    frc_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_load (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .in_load  (in_load),
        .in_byte  (s_tdata),
        .result   (result)
    );

    frc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_load),
        .result   (result),
        .ready    (stage_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/frc_checker.sv
// ---------------------------------------------------------------------------
// frc_checker
// Port-level checks of the frame receiver checksum block, bound to the top.
// ---------------------------------------------------------------------------
`include "frame_receiver_checksum_macros.svh"

module frc_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [frc_pkg::FRC_OUT_TDATA_W-1:0]    m_tdata,
    input  logic [frc_pkg::FRC_STATUS_W-1:0]       m_tuser
);
    import frc_pkg::*;

    // stalled result holds
    `FRC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // every input transfer shows a result in the next cycle
    `FRC_ASSERT_NEXT(a_result, s_tvalid && s_tready, m_tvalid)

    // input only backs off while a result is stuck
    `FRC_ASSERT_NOW(a_ready, !s_tready, m_tvalid && !m_tready)

    // payload fields are zero outside payload results
    `FRC_ASSERT_NOW(a_zero, m_tvalid && m_tuser != ST_DATA, m_tdata[23:0] == 24'd0)

endmodule

bind frame_receiver_checksum frc_checker u_frc_checker (.*);
